// ----- src/fdd_pkg.sv -----
// fdd_pkg: shared types for the fixed-size block dedup counter
// no dependencies; used by fdd_cell and fixed_block_dedup_counter
package fdd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic        block_unique;
    logic        table_full;
    logic [6:0]  unique_count;
    logic [15:0] total_blocks;
  } out_t;

  // control that rides along the cell chain with each byte beat
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } ctl_t;

  localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

endpackage

// ----- src/fdd_cell.sv -----
// fdd_cell: one table entry of the dedup chain, with its own byte store
// depends on fdd_pkg (ctl_t)
module fdd_cell import fdd_pkg::*; #(
  parameter int BLOCK_BYTES = 64,
  parameter int IDX         = 0,
  parameter int PW          = 6,
  parameter int LW          = 7,
  parameter int CW          = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          in_ctl,
  input  logic [7:0]    in_byte,
  input  logic [PW-1:0] in_pos,
  input  logic [LW-1:0] in_len,
  input  logic [CW-1:0] count,
  input  logic          commit,
  input  logic [LW-1:0] commit_len,
  output ctl_t          out_ctl,
  output logic [7:0]    out_byte,
  output logic [PW-1:0] out_pos,
  output logic [LW-1:0] out_len
);

  logic [7:0]    mem [BLOCK_BYTES];
  logic [7:0]    rd_r;
  ctl_t          ctl_r;
  logic [7:0]    byte_r;
  logic [PW-1:0] pos_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] elen_r;
  logic          match_r, match_nxt;
  logic          eq, in_use, hit_here;

  wire free_cell = (count == CW'(IDX));

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      rd_r <= mem[in_pos];
      // the free entry gathers the block tentatively
      if (free_cell) begin
        mem[in_pos] <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      match_r <= 1'b0;
    end else begin
      ctl_r   <= in_ctl;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= in_byte;
    pos_r  <= in_pos;
    len_r  <= in_len;
    if (commit && free_cell) begin
      elen_r <= commit_len;
    end
  end

  assign eq       = (rd_r == byte_r);
  assign in_use   = (CW'(IDX) < count);
  assign hit_here = ctl_r.valid && ctl_r.last && in_use && eq && (elen_r == len_r)
                    && ((pos_r == '0) || match_r);

  always_comb begin
    match_nxt = match_r;
    if (ctl_r.valid) begin
      match_nxt = eq && ((pos_r == '0) || match_r);
    end
  end

  always_comb begin
    out_ctl     = ctl_r;
    out_ctl.hit = ctl_r.hit || hit_here;
  end

  assign out_byte = byte_r;
  assign out_pos  = pos_r;
  assign out_len  = len_r;

endmodule

// ----- src/fixed_block_dedup_counter.sv -----
// fixed_block_dedup_counter: top level, byte gathering, cell chain and counters
// depends on fdd_pkg and fdd_cell
// a byte beat walks the MAX_BLOCKS cells, registered in each; a block result is
// registered in the cycle after its closing byte leaves the chain
// a new byte is taken only once the last one has left the chain (busy until then)
// reset: synchronous active-low clears position, counts and chain valids;
// entry stores stay undefined until written; the receiver cannot stall
module fixed_block_dedup_counter import fdd_pkg::*; #(
  parameter int BLOCK_BYTES = 64,
  parameter int MAX_BLOCKS  = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int PW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int LW = $clog2(BLOCK_BYTES + 1);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // chain wiring: link i feeds cell i, link MAX_BLOCKS is the tail
  ctl_t          ch_ctl  [MAX_BLOCKS+1];
  logic [7:0]    ch_byte [MAX_BLOCKS+1];
  logic [PW-1:0] ch_pos  [MAX_BLOCKS+1];
  logic [LW-1:0] ch_len  [MAX_BLOCKS+1];

  logic          busy_r, busy_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_item_r, out_item_nxt;
  logic          accept, last_byte, commit, tail_done, unique_blk;

  assign accept    = start && !busy_r;
  assign last_byte = in_item.end_of_file || (pos_r == PW'(BLOCK_BYTES - 1));

  // head beat enters cell 0 in the accept cycle
  assign ch_ctl[0]  = '{valid: accept, last: last_byte, hit: 1'b0};
  assign ch_byte[0] = in_item.data_byte;
  assign ch_pos[0]  = pos_r;
  assign ch_len[0]  = LW'(pos_r) + LW'(1);

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fdd_cell #(
      .BLOCK_BYTES(BLOCK_BYTES), .IDX(i),
      .PW(PW), .LW(LW), .CW(CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_ctl     (ch_ctl[i]),
      .in_byte    (ch_byte[i]),
      .in_pos     (ch_pos[i]),
      .in_len     (ch_len[i]),
      .count      (count_r),
      .commit     (commit),
      .commit_len (ch_len[MAX_BLOCKS]),
      .out_ctl    (ch_ctl[i+1]),
      .out_byte   (ch_byte[i+1]),
      .out_pos    (ch_pos[i+1]),
      .out_len    (ch_len[i+1])
    );
  end

  // tail of the chain: block decision
  assign tail_done  = ch_ctl[MAX_BLOCKS].valid && ch_ctl[MAX_BLOCKS].last;
  assign unique_blk = !ch_ctl[MAX_BLOCKS].hit;
  assign commit     = tail_done && unique_blk && (count_r < CW'(MAX_BLOCKS));

  always_comb begin
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pos_nxt  = last_byte ? '0 : pos_r + PW'(1);
    end
    if (ch_ctl[MAX_BLOCKS].valid) begin
      busy_nxt = 1'b0;
    end
    if (tail_done) begin
      if (commit) begin
        count_nxt = count_r + CW'(1);
      end
      if (total_r != TOTAL_MAX) begin
        total_nxt = total_r + 16'd1;
      end
      out_valid_nxt             = 1'b1;
      out_item_nxt.block_unique = unique_blk;
      out_item_nxt.table_full   = unique_blk && !commit;
      out_item_nxt.unique_count = 7'(count_nxt);
      out_item_nxt.total_blocks = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // a beat leaving the chain only while a byte is in flight
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ctl[MAX_BLOCKS].valid |-> busy_r) else $error("tail beat while idle");
  // accepted byte keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r) else $error("busy not raised");
  // table never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS)) else $error("count overflow");
  // a result follows a closing beat at the tail
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(tail_done)) else $error("stray result");
`endif

endmodule
